// File: hdl/cpc_pkg.sv
// Package with shared types, constants and the case-folding function of the caseless pattern counter.
`timescale 1ns / 1ps

package cpc_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int PATTERN_BYTES   = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_REG_W       = 5;
    localparam int MATCH_COUNT_W   = 32;

    typedef logic [7:0] t_byte;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [LEN_REG_W-1:0] t_len_reg;
    typedef logic [MATCH_COUNT_W-1:0] t_match_count;
    typedef logic [PATTERN_BYTES-1:0][7:0] t_pattern;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LO  = 2'd0,
        CFG_PATTERN_HI  = 2'd1,
        CFG_PATTERN_LEN = 2'd2
    } t_cfg_reg;

    // Folds ASCII upper-case letters to lower case and leaves every other byte alone.
    function automatic t_byte fold_case(input t_byte c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

// File: hdl/cpc_if.sv
// Channel interfaces for text input, results and configuration writes.
`timescale 1ns / 1ps

interface cpc_text_if;
    logic              valid;
    logic              ready;
    cpc_pkg::t_byte    text_byte;
    logic              end_of_chunk;

    modport source (output valid, output text_byte, output end_of_chunk, input ready);
    modport sink (input valid, input text_byte, input end_of_chunk, output ready);
endinterface

interface cpc_result_if;
    logic                  valid;
    logic                  ready;
    logic                  matched;
    cpc_pkg::t_match_count match_count;

    modport source (output valid, output matched, output match_count, input ready);
    modport sink (input valid, input matched, input match_count, output ready);
endinterface

interface cpc_cfg_if;
    logic                valid;
    logic                ready;
    cpc_pkg::t_cfg_index index;
    cpc_pkg::t_cfg_data  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/caseless_pattern_counter_top.sv
// Top level of the caseless pattern counter with its state, configuration and result buffer.
// The result of an accepted text transaction is registered in the output buffer before it reaches the output.
// Throughput: one text byte per cycle while the skid entry is empty, set by the combinational window compare.
// A two-entry output buffer keeps input accepted while one result waits downstream.
// Reset clears the count, fill level, holdoff and buffer; the pattern resets to zero
// with a length of one.
`timescale 1ns / 1ps

module caseless_pattern_counter_top #(
    parameter int MAX_PATTERN = cpc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = cpc_pkg::COUNT_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpc_text_if.sink      i_text,
    cpc_result_if.source  o_result,
    cpc_cfg_if.sink       i_cfg
);
    import cpc_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int HW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WB = (COUNT_BITS > MATCH_COUNT_W) ? COUNT_BITS : MATCH_COUNT_W;

    t_pattern                   r_pattern;
    t_len_reg                   r_pattern_len;
    logic [MAX_PATTERN-1:0][7:0] r_history;
    logic [LW-1:0]              r_filled;
    logic [HW-1:0]              r_holdoff;
    logic [COUNT_BITS-1:0]      r_tally;

    logic                       r_out_valid;
    logic                       r_out_matched;
    t_match_count               r_out_count;
    logic                       r_skid_valid;
    logic                       r_skid_matched;
    t_match_count               r_skid_count;

    logic [MAX_PATTERN-1:0][7:0] window;
    logic [LW-1:0]              len_eff;
    logic [LW-1:0]              n_filled;
    logic                       raw_hit;
    logic                       n_matched;
    logic [HW-1:0]              n_holdoff;
    logic [COUNT_BITS-1:0]      n_tally;
    logic [WB-1:0]              tally_wide;
    t_match_count               n_count;
    logic                       accept;
    logic                       pop;

    assign i_cfg.ready  = 1'b1;
    assign i_text.ready = !r_skid_valid;
    assign accept       = i_text.valid && !r_skid_valid;
    assign pop          = r_out_valid && o_result.ready;

    assign o_result.valid       = r_out_valid;
    assign o_result.matched     = r_out_matched;
    assign o_result.match_count = r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_pattern_len <= LEN_REG_W'(1);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_PATTERN_LO: begin
                    for (int b = 0; b < 8; b++) begin
                        r_pattern[b] <= fold_case(i_cfg.data[b*8 +: 8]);
                    end
                end
                CFG_PATTERN_HI: begin
                    for (int b = 0; b < 8; b++) begin
                        r_pattern[b + 8] <= fold_case(i_cfg.data[b*8 +: 8]);
                    end
                end
                CFG_PATTERN_LEN: begin
                    r_pattern_len <= i_cfg.data[LEN_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        window[0] = fold_case(i_text.text_byte);
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window[k] = r_history[k-1];
        end
        if (r_pattern_len > LEN_REG_W'(MAX_PATTERN)) begin
            len_eff = LW'(MAX_PATTERN);
        end else begin
            len_eff = LW'(r_pattern_len);
        end
        if (r_filled < LW'(MAX_PATTERN)) begin
            n_filled = r_filled + LW'(1);
        end else begin
            n_filled = r_filled;
        end
    end

    cpc_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_match (
        .i_window  (window),
        .i_pattern (r_pattern),
        .i_len     (len_eff),
        .i_filled  (n_filled),
        .o_hit     (raw_hit)
    );

    always_comb begin
        n_matched = 1'b0;
        n_holdoff = r_holdoff;
        n_tally   = r_tally;
        if (r_holdoff != '0) begin
            n_holdoff = r_holdoff - HW'(1);
        end else if (raw_hit) begin
            n_matched = 1'b1;
            n_holdoff = HW'(len_eff - LW'(1));
            if (r_tally != '1) begin
                n_tally = r_tally + COUNT_BITS'(1);
            end
        end
        tally_wide = WB'(n_tally);
        if (tally_wide > WB'({MATCH_COUNT_W{1'b1}})) begin
            n_count = '1;
        end else begin
            n_count = tally_wide[MATCH_COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled  <= '0;
            r_holdoff <= '0;
            r_tally   <= '0;
        end else if (accept) begin
            if (i_text.end_of_chunk) begin
                r_filled  <= '0;
                r_holdoff <= '0;
                r_tally   <= '0;
            end else begin
                r_filled  <= n_filled;
                r_holdoff <= n_holdoff;
                r_tally   <= n_tally;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_history <= window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out_matched <= r_skid_matched;
                r_out_count   <= r_skid_count;
            end else begin
                r_out_matched <= n_matched;
                r_out_count   <= n_count;
            end
        end else if (accept) begin
            r_skid_matched <= n_matched;
            r_skid_count   <= n_count;
        end
    end

endmodule

// File: hdl/cpc_match.sv
// Window comparator that checks the newest text bytes against the folded pattern.
`timescale 1ns / 1ps

module cpc_match #(
    parameter int MAX_PATTERN = cpc_pkg::MAX_PATTERN_DEF,
    parameter int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN-1:0][7:0] i_window,
    input  cpc_pkg::t_pattern           i_pattern,
    input  logic [LW-1:0]               i_len,
    input  logic [LW-1:0]               i_filled,
    output logic                        o_hit
);
    import cpc_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic          all_eq;
    logic [LW-1:0] idx;

    always_comb begin
        all_eq = 1'b1;
        idx    = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx = i_len - LW'(j + 1);
            if (LW'(j) < i_len && i_window[idx[IW-1:0]] != i_pattern[j]) begin
                all_eq = 1'b0;
            end
        end
        o_hit = (i_len != '0) && (i_filled >= i_len) && all_eq;
    end

endmodule
